@@ hdl/vgdf_pkg.sv @@
// Shared constants, command/status types and controller states of the voxel dedup filter.
`timescale 1ns / 1ps

package vgdf_pkg;

  localparam int COORD_W     = 32;
  localparam int INV_W       = 25;
  localparam int INDEX_BITS  = 20;
  localparam int KEY_W       = 3 * INDEX_BITS;
  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int EPOCH_W     = 8;
  localparam int ENTRY_W     = EPOCH_W + KEY_W;
  localparam int PROD_W      = 2 * COORD_W;

  localparam logic [INV_W-1:0]   INV_RESET = INV_W'(655360);
  localparam logic [COORD_W-1:0] PRIME_X   = 32'd73856093;
  localparam logic [COORD_W-1:0] PRIME_Y   = 32'd19349663;
  localparam logic [COORD_W-1:0] PRIME_Z   = 32'd83492791;
  localparam logic [INV_W-1:0]   IDX_LIM   = INV_W'(1) << (INDEX_BITS - 1);

  typedef enum logic [3:0] {
    ST_INIT_CLR,
    ST_IDLE,
    ST_FRAME_CLR,
    ST_AX,
    ST_AY,
    ST_AZ,
    ST_HX,
    ST_HY,
    ST_HZ,
    ST_HASH,
    ST_RD,
    ST_CMP,
    ST_EMIT_OK,
    ST_EMIT_OVF
  } ctrl_state_t;

  typedef enum logic [2:0] {
    MUL_AX,
    MUL_AY,
    MUL_AZ,
    MUL_HX,
    MUL_HY,
    MUL_HZ
  } mul_sel_t;

  typedef enum logic [2:0] {
    CAP_NONE,
    CAP_IX,
    CAP_IY,
    CAP_IZ,
    CAP_H0,
    CAP_H1,
    CAP_H2
  } cap_sel_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    cap_sel_t cap_sel;
    logic     rd_en;
    logic     wr_key;
    logic     clr_wr;
    logic     probe_next;
    logic     epoch_adv;
    logic     epoch_rst;
    logic     emit;
    logic     emit_ovf;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic slot_match;
    logic probe_last;
    logic clr_last;
    logic epoch_max;
    logic out_free;
  } dp_status_t;

endpackage

@@ hdl/vgdf_datapath.sv @@
// Datapath: shared multiplier, voxel index and hash registers, voxel table and output register.
`timescale 1ns / 1ps

module vgdf_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  vgdf_pkg::ctrl_cmd_t                 cmd,
  output vgdf_pkg::dp_status_t                status,
  input  logic signed [vgdf_pkg::COORD_W-1:0] point_x,
  input  logic signed [vgdf_pkg::COORD_W-1:0] point_y,
  input  logic signed [vgdf_pkg::COORD_W-1:0] point_z,
  input  logic                                cfg_valid,
  input  logic [vgdf_pkg::INV_W-1:0]          inv_voxel_size,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [vgdf_pkg::COORD_W-1:0] kept_x,
  output logic signed [vgdf_pkg::COORD_W-1:0] kept_y,
  output logic signed [vgdf_pkg::COORD_W-1:0] kept_z,
  output logic                                table_overflow
);

  // magnitude of a two's complement coordinate (most negative value fits unsigned)
  function automatic logic [vgdf_pkg::COORD_W-1:0] axis_mag(
    input logic [vgdf_pkg::COORD_W-1:0] v
  );
    return v[vgdf_pkg::COORD_W-1] ? (vgdf_pkg::COORD_W'(0) - v) : v;
  endfunction

  // truncated quotient back to a saturated signed index
  function automatic logic [vgdf_pkg::INDEX_BITS-1:0] axis_sat(
    input logic [vgdf_pkg::INV_W-1:0] q,
    input logic                       neg
  );
    logic [vgdf_pkg::INDEX_BITS-1:0] res;
    if (neg) begin
      if (q > vgdf_pkg::IDX_LIM) begin
        res = {1'b1, {(vgdf_pkg::INDEX_BITS-1){1'b0}}};
      end else begin
        res = vgdf_pkg::INDEX_BITS'(0) - q[vgdf_pkg::INDEX_BITS-1:0];
      end
    end else begin
      if (q >= vgdf_pkg::IDX_LIM) begin
        res = {1'b0, {(vgdf_pkg::INDEX_BITS-1){1'b1}}};
      end else begin
        res = q[vgdf_pkg::INDEX_BITS-1:0];
      end
    end
    return res;
  endfunction

  function automatic logic [vgdf_pkg::COORD_W-1:0] sext_idx(
    input logic [vgdf_pkg::INDEX_BITS-1:0] i
  );
    return {{(vgdf_pkg::COORD_W-vgdf_pkg::INDEX_BITS){i[vgdf_pkg::INDEX_BITS-1]}}, i};
  endfunction

  logic signed [vgdf_pkg::COORD_W-1:0] pt_x, pt_y, pt_z;
  logic [vgdf_pkg::INV_W-1:0]          inv;
  logic [vgdf_pkg::COORD_W-1:0]        mul_a, mul_b;
  logic [vgdf_pkg::PROD_W-1:0]         prod;
  logic [vgdf_pkg::INV_W-1:0]          quot;
  logic [vgdf_pkg::INDEX_BITS-1:0]     ix, iy, iz;
  logic [vgdf_pkg::ADDR_W-1:0]         hash;
  logic [vgdf_pkg::ADDR_W-1:0]         probe_addr;
  logic [vgdf_pkg::ADDR_W-1:0]         probe_cnt;
  logic [vgdf_pkg::ADDR_W-1:0]         clr_addr;
  logic [vgdf_pkg::EPOCH_W-1:0]        epoch;
  logic [vgdf_pkg::KEY_W-1:0]          key;
  logic [vgdf_pkg::ENTRY_W-1:0]        mem [vgdf_pkg::TABLE_DEPTH];
  logic [vgdf_pkg::ENTRY_W-1:0]        rdata;
  logic                                wr_en;
  logic [vgdf_pkg::ADDR_W-1:0]         wr_addr;
  logic [vgdf_pkg::ENTRY_W-1:0]        wr_data;
  logic                                out_free;

  assign key  = {iz, iy, ix};
  assign quot = prod[vgdf_pkg::COORD_W +: vgdf_pkg::INV_W];

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      inv <= vgdf_pkg::INV_RESET;
    end else if (cfg_valid) begin
      inv <= inv_voxel_size;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pt_x <= point_x;
      pt_y <= point_y;
      pt_z <= point_z;
    end
  end

  // one shared multiplier, product registered
  always_comb begin
    mul_a = axis_mag(pt_x);
    mul_b = vgdf_pkg::COORD_W'(inv);
    case (cmd.mul_sel)
      vgdf_pkg::MUL_AX: begin
        mul_a = axis_mag(pt_x);
        mul_b = vgdf_pkg::COORD_W'(inv);
      end
      vgdf_pkg::MUL_AY: begin
        mul_a = axis_mag(pt_y);
        mul_b = vgdf_pkg::COORD_W'(inv);
      end
      vgdf_pkg::MUL_AZ: begin
        mul_a = axis_mag(pt_z);
        mul_b = vgdf_pkg::COORD_W'(inv);
      end
      vgdf_pkg::MUL_HX: begin
        mul_a = sext_idx(ix);
        mul_b = vgdf_pkg::PRIME_X;
      end
      vgdf_pkg::MUL_HY: begin
        mul_a = sext_idx(iy);
        mul_b = vgdf_pkg::PRIME_Y;
      end
      vgdf_pkg::MUL_HZ: begin
        mul_a = sext_idx(iz);
        mul_b = vgdf_pkg::PRIME_Z;
      end
      default: begin
        mul_a = axis_mag(pt_x);
        mul_b = vgdf_pkg::COORD_W'(inv);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= vgdf_pkg::PROD_W'(mul_a) * vgdf_pkg::PROD_W'(mul_b);
  end

  // index, hash and probe pointer capture
  always_ff @(posedge clk) begin
    case (cmd.cap_sel)
      vgdf_pkg::CAP_IX: ix <= axis_sat(quot, pt_x[vgdf_pkg::COORD_W-1]);
      vgdf_pkg::CAP_IY: iy <= axis_sat(quot, pt_y[vgdf_pkg::COORD_W-1]);
      vgdf_pkg::CAP_IZ: iz <= axis_sat(quot, pt_z[vgdf_pkg::COORD_W-1]);
      vgdf_pkg::CAP_H0: hash <= prod[vgdf_pkg::ADDR_W-1:0];
      vgdf_pkg::CAP_H1: hash <= hash ^ prod[vgdf_pkg::ADDR_W-1:0];
      vgdf_pkg::CAP_H2: begin
        probe_addr <= hash ^ prod[vgdf_pkg::ADDR_W-1:0];
        probe_cnt  <= '0;
      end
      default: begin
      end
    endcase
    if (cmd.probe_next) begin
      probe_addr <= probe_addr + 1'b1;
      probe_cnt  <= probe_cnt + 1'b1;
    end
  end

  // frame epoch; zero never marks a live entry
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch    <= vgdf_pkg::EPOCH_W'(1);
      clr_addr <= '0;
    end else begin
      if (cmd.epoch_rst) begin
        epoch <= vgdf_pkg::EPOCH_W'(1);
      end else if (cmd.epoch_adv) begin
        epoch <= epoch + 1'b1;
      end
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // voxel table: one write and one registered read port
  always_comb begin
    wr_en   = cmd.clr_wr || cmd.wr_key;
    wr_addr = cmd.clr_wr ? clr_addr : probe_addr;
    wr_data = cmd.clr_wr ? '0 : {epoch, key};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata <= mem[probe_addr];
    end
  end

  // output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kept_x         <= pt_x;
      kept_y         <= pt_y;
      kept_z         <= pt_z;
      table_overflow <= cmd.emit_ovf;
    end
  end

  always_comb begin
    status.slot_free  = rdata[vgdf_pkg::ENTRY_W-1 -: vgdf_pkg::EPOCH_W] != epoch;
    status.slot_match = !status.slot_free && (rdata[vgdf_pkg::KEY_W-1:0] == key);
    status.probe_last = probe_cnt == vgdf_pkg::ADDR_W'(vgdf_pkg::TABLE_DEPTH - 1);
    status.clr_last   = clr_addr == vgdf_pkg::ADDR_W'(vgdf_pkg::TABLE_DEPTH - 1);
    status.epoch_max  = &epoch;
    status.out_free   = out_free;
  end

  a_wr_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.clr_wr && cmd.wr_key))
    else $error("table write and clear in the same cycle");

  a_epoch_live: assert property (@(posedge clk) disable iff (rst)
    epoch != '0)
    else $error("epoch reached the cleared mark");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid && $past(out_free))
    else $error("result loaded over a pending result");

endmodule

@@ hdl/vgdf_ctrl.sv @@
// Controller: sequences multiply, hash, table probe, clearing and result hand-off.
`timescale 1ns / 1ps

module vgdf_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  frame_start,
  output logic                  in_stall,
  input  vgdf_pkg::dp_status_t  status,
  output vgdf_pkg::ctrl_cmd_t   cmd
);

  vgdf_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vgdf_pkg::ST_INIT_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    in_stall       = 1'b1;
    cmd            = '0;
    cmd.mul_sel    = vgdf_pkg::MUL_AX;
    cmd.cap_sel    = vgdf_pkg::CAP_NONE;
    case (state)
      vgdf_pkg::ST_INIT_CLR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          cmd.epoch_rst = 1'b1;
          state_next    = vgdf_pkg::ST_IDLE;
        end
      end
      vgdf_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (frame_start && status.epoch_max) begin
            state_next = vgdf_pkg::ST_FRAME_CLR;
          end else begin
            cmd.epoch_adv = frame_start;
            state_next    = vgdf_pkg::ST_AX;
          end
        end
      end
      vgdf_pkg::ST_FRAME_CLR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          cmd.epoch_rst = 1'b1;
          state_next    = vgdf_pkg::ST_AX;
        end
      end
      vgdf_pkg::ST_AX: begin
        cmd.mul_sel = vgdf_pkg::MUL_AX;
        state_next  = vgdf_pkg::ST_AY;
      end
      vgdf_pkg::ST_AY: begin
        cmd.mul_sel = vgdf_pkg::MUL_AY;
        cmd.cap_sel = vgdf_pkg::CAP_IX;
        state_next  = vgdf_pkg::ST_AZ;
      end
      vgdf_pkg::ST_AZ: begin
        cmd.mul_sel = vgdf_pkg::MUL_AZ;
        cmd.cap_sel = vgdf_pkg::CAP_IY;
        state_next  = vgdf_pkg::ST_HX;
      end
      vgdf_pkg::ST_HX: begin
        cmd.mul_sel = vgdf_pkg::MUL_HX;
        cmd.cap_sel = vgdf_pkg::CAP_IZ;
        state_next  = vgdf_pkg::ST_HY;
      end
      vgdf_pkg::ST_HY: begin
        cmd.mul_sel = vgdf_pkg::MUL_HY;
        cmd.cap_sel = vgdf_pkg::CAP_H0;
        state_next  = vgdf_pkg::ST_HZ;
      end
      vgdf_pkg::ST_HZ: begin
        cmd.mul_sel = vgdf_pkg::MUL_HZ;
        cmd.cap_sel = vgdf_pkg::CAP_H1;
        state_next  = vgdf_pkg::ST_HASH;
      end
      vgdf_pkg::ST_HASH: begin
        cmd.cap_sel = vgdf_pkg::CAP_H2;
        state_next  = vgdf_pkg::ST_RD;
      end
      vgdf_pkg::ST_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = vgdf_pkg::ST_CMP;
      end
      vgdf_pkg::ST_CMP: begin
        if (status.slot_free) begin
          cmd.wr_key = 1'b1;
          state_next = vgdf_pkg::ST_EMIT_OK;
        end else if (status.slot_match) begin
          state_next = vgdf_pkg::ST_IDLE;
        end else if (status.probe_last) begin
          state_next = vgdf_pkg::ST_EMIT_OVF;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = vgdf_pkg::ST_RD;
        end
      end
      vgdf_pkg::ST_EMIT_OK: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = vgdf_pkg::ST_IDLE;
        end
      end
      vgdf_pkg::ST_EMIT_OVF: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_ovf = 1'b1;
          state_next   = vgdf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = vgdf_pkg::ST_IDLE;
      end
    endcase
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=>
      (state == vgdf_pkg::ST_AX || state == vgdf_pkg::ST_FRAME_CLR))
    else $error("accepted request did not start processing");

  a_cmp_after_rd: assert property (@(posedge clk) disable iff (rst)
    (state == vgdf_pkg::ST_CMP) |-> ($past(state) == vgdf_pkg::ST_RD))
    else $error("compare without a table read");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state != vgdf_pkg::ST_IDLE) |-> in_stall)
    else $error("input open while busy");

endmodule

@@ hdl/voxel_grid_dedup_filter_unit.sv @@
// Top level of the voxel grid dedup filter: controller plus datapath.
`timescale 1ns / 1ps

// Voxel grid dedup filter: keeps the first point of each voxel within a frame.
// Input channel (in_valid / in_stall): a request carries frame_start and a
//   signed Q16.16 point; it is accepted when in_valid is high and in_stall low.
//   frame_start clears the voxel table before that point is handled.
// Output channel (out_valid / out_stall): a kept point, unchanged, plus
//   table_overflow when the table was full and the point went through unrecorded.
//   A dropped duplicate yields no output request.
// Config (cfg_valid / cfg_ready): inv_voxel_size, reciprocal voxel edge; cfg_ready
//   is always high, write only while the block is idle.
// Sequencing: one request at a time. Three axis multiplies and three hash multiplies
//   share one multiplier, then each table probe is a read step and a compare step.
//   A dropped request returns to idle straight from the compare; a kept one waits
//   for the output register, and its result appears in the cycle after hand-off.
// Table clearing uses a frame epoch stored per entry, so frame_start is free,
//   except every 255th frame where a clearing pass over the whole table runs first.
// Reset: a clearing pass over the whole table runs before the first request is taken.
// Out stall: a finished result waits in the output register; a following result
//   holds the block until that register frees.

module voxel_grid_dedup_filter_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                frame_start,
  input  logic signed [vgdf_pkg::COORD_W-1:0] point_x,
  input  logic signed [vgdf_pkg::COORD_W-1:0] point_y,
  input  logic signed [vgdf_pkg::COORD_W-1:0] point_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [vgdf_pkg::COORD_W-1:0] kept_x,
  output logic signed [vgdf_pkg::COORD_W-1:0] kept_y,
  output logic signed [vgdf_pkg::COORD_W-1:0] kept_z,
  output logic                                table_overflow,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vgdf_pkg::INV_W-1:0]          inv_voxel_size
);

  vgdf_pkg::ctrl_cmd_t  cmd;
  vgdf_pkg::dp_status_t status;

  // the user must write the register only while idle (the block does not enforce it), so always ready
  assign cfg_ready = 1'b1;

  vgdf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .frame_start (frame_start),
    .in_stall    (in_stall),
    .status      (status),
    .cmd         (cmd)
  );

  vgdf_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .point_x        (point_x),
    .point_y        (point_y),
    .point_z        (point_z),
    .cfg_valid      (cfg_valid),
    .inv_voxel_size (inv_voxel_size),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .kept_x         (kept_x),
    .kept_y         (kept_y),
    .kept_z         (kept_z),
    .table_overflow (table_overflow)
  );

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the voxel grid dedup filter unit.
`timescale 1ns / 1ps

// Stimulus runs as a list of phases. Between phases the block is drained and
// left to settle, then inv_voxel_size may be rewritten.
//   - Directed: truncation toward zero, voxel edges, saturation of the index,
//     repeats inside a frame, frame_start clearing, a zero register value.
//   - Table fill: 4096 distinct voxels whose probe starts are all different,
//     then repeats (still dropped) and new voxels (overflow pass-through).
//   - Random: clustered points for duplicates, mid-range, full 32-bit and
//     corner values, with frame_start at a per-phase rate. The frame count
//     runs past 255, so the epoch wrap clearing pass is exercised as well.
// A driver and a monitor run as clocked processes. The driver predicts each
// accepted request against a private copy of the voxel table. The monitor
// compares every result with the oldest expectation.

module tb;

  localparam int          DEPTH          = 4096;
  localparam int          IDX_W          = 20;
  localparam logic [31:0] HASH_PX        = 32'd73856093;
  localparam logic [31:0] HASH_PY        = 32'd19349663;
  localparam logic [31:0] HASH_PZ        = 32'd83492791;
  localparam logic [63:0] IDX_HALF       = 64'd1 << (IDX_W - 1);
  localparam logic [24:0] INV_AT_RESET   = 25'd655360;
  localparam logic [24:0] INV_UNIT       = 25'd65536;
  localparam logic [24:0] INV_MAX        = 25'd16777216;
  // Full-table search plus a possible epoch clearing pass.
  localparam int          SETTLE_CYCLES  = 12500;
  localparam int          DRAIN_LIMIT    = 200000;
  localparam int          CYCLE_LIMIT    = 3000000;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          RAND_PHASES    = 8;
  localparam int          RAND_PER_PHASE = 225;
  localparam int          MAX_PRINT      = 100;

  typedef enum logic [1:0] {IDLE_OFF, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic        frame_start;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_req_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        overflow;
  } kept_point_t;

  logic                           clk            = 1'b0;
  logic                           rst            = 1'b1;
  logic                           in_valid       = 1'b0;
  logic                           in_stall;
  logic                           frame_start    = 1'b0;
  logic [vgdf_pkg::COORD_W-1:0]   point_x        = '0;
  logic [vgdf_pkg::COORD_W-1:0]   point_y        = '0;
  logic [vgdf_pkg::COORD_W-1:0]   point_z        = '0;
  logic                           out_valid;
  logic                           out_stall      = 1'b0;
  logic [vgdf_pkg::COORD_W-1:0]   kept_x;
  logic [vgdf_pkg::COORD_W-1:0]   kept_y;
  logic [vgdf_pkg::COORD_W-1:0]   kept_z;
  logic                           table_overflow;
  logic                           cfg_valid      = 1'b0;
  logic                           cfg_ready;
  logic [vgdf_pkg::INV_W-1:0]     inv_voxel_size = INV_AT_RESET;

  // Predicted block state: the voxel table and the active reciprocal size.
  bit          slot_used [DEPTH];
  logic [59:0] slot_key  [DEPTH];
  logic [24:0] inv_now = INV_AT_RESET;

  point_req_t  pending_pts [$];
  point_req_t  recent_pts  [$];
  kept_point_t kept_expect [$];

  idle_mode_t  idle_mode = IDLE_OFF;
  logic        hold_req  = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;

  voxel_grid_dedup_filter_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .frame_start    (frame_start),
    .point_x        (point_x),
    .point_y        (point_y),
    .point_z        (point_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kept_x         (kept_x),
    .kept_y         (kept_y),
    .kept_z         (kept_z),
    .table_overflow (table_overflow),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .inv_voxel_size (inv_voxel_size)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // One axis: |raw| * inv in Q32.32, truncated toward zero, sign restored,
  // then clamped to a 20-bit signed index.
  function automatic logic [31:0] voxel_index(input logic [31:0] raw);
    logic [31:0] mag;
    logic [63:0] q;
    mag = raw[31] ? (~raw + 32'd1) : raw;
    q   = ({32'd0, mag} * {39'd0, inv_now}) >> 32;
    if (raw[31]) begin
      if (q > IDX_HALF) q = IDX_HALF;
      return 32'd0 - q[31:0];
    end
    if (q > IDX_HALF - 1) q = IDX_HALF - 1;
    return q[31:0];
  endfunction

  // Returns 1 when the point is passed on; res then holds the expected result.
  function automatic bit filter_point(input point_req_t p, output kept_point_t res);
    logic [31:0] ix, iy, iz, h;
    logic [59:0] key;
    int unsigned pos;
    bit          found_free;
    found_free = 1'b0;
    if (p.frame_start) begin
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    end
    ix  = voxel_index(p.x);
    iy  = voxel_index(p.y);
    iz  = voxel_index(p.z);
    key = {iz[IDX_W-1:0], iy[IDX_W-1:0], ix[IDX_W-1:0]};
    h   = (ix * HASH_PX) ^ (iy * HASH_PY) ^ (iz * HASH_PZ);
    pos = h[IDX_W-1:0] % DEPTH;
    // linear probe over the whole table; a full table with no match overflows
    for (int n = 0; n < DEPTH; n++) begin
      if (!slot_used[pos]) begin
        found_free = 1'b1;
        break;
      end
      if (slot_key[pos] == key) return 1'b0;
      pos = (pos + 1) % DEPTH;
    end
    res.x        = p.x;
    res.y        = p.y;
    res.z        = p.z;
    res.overflow = !found_free;
    if (found_free) begin
      slot_used[pos] = 1'b1;
      slot_key[pos]  = key;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic int unsigned gap_pct(input bit recv);
    case (idle_mode)
      IDLE_SEND: return recv ? 0 : 45;
      IDLE_RECV: return recv ? 45 : 0;
      IDLE_BOTH: return 8;
      default:   return 0;
    endcase
  endfunction

  function automatic logic [31:0] corner_word();
    case ($urandom_range(0, 4))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Mix: jittered repeats of recent points (duplicates), +-16 m points,
  // full-range words and corner values (saturation).
  function automatic point_req_t random_point(input int unsigned fs_pct);
    point_req_t  p;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 40 && recent_pts.size() != 0) begin
      p = recent_pts[$urandom_range(0, recent_pts.size() - 1)];
      p.x[7:0] = $urandom_range(0, 255);
      p.y[7:0] = $urandom_range(0, 255);
      p.z[7:0] = $urandom_range(0, 255);
    end else if (kind < 70) begin
      p.x = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      p.y = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      p.z = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    end else if (kind < 85) begin
      p.x = $urandom();
      p.y = $urandom();
      p.z = $urandom();
    end else begin
      p.x = corner_word();
      p.y = corner_word();
      p.z = corner_word();
    end
    p.frame_start = chance(fs_pct);
    recent_pts.push_back(p);
    if (recent_pts.size() > 16) void'(recent_pts.pop_front());
    return p;
  endfunction

  task automatic add_point(input bit fs, input logic [31:0] x, y, z);
    point_req_t p;
    p.frame_start = fs;
    p.x           = x;
    p.y           = y;
    p.z           = z;
    pending_pts.push_back(p);
  endtask

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINT) $display("ERROR @%0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Register write; only called with the block idle.
  task automatic write_inv(input logic [24:0] val);
    @(posedge clk);
    cfg_valid      <= 1'b1;
    inv_voxel_size <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    inv_now    = val;
  endtask

  // Wait for every request to go in and every result to come out, then let a
  // trailing dropped request (possibly a full-table search) finish.
  task automatic drain_phase();
    int unsigned waited;
    kept_point_t lost;
    waited = 0;
    while (pending_pts.size() != 0 || in_valid) @(posedge clk);
    while (kept_expect.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    while (kept_expect.size() != 0) begin
      lost = kept_expect.pop_front();
      report_mismatch($sformatf("missing result x=%h y=%h z=%h ovf=%b",
                                lost.x, lost.y, lost.z, lost.overflow));
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued requests, predicts each one at acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    point_req_t  req;
    point_req_t  nxt;
    kept_point_t res;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        req.frame_start = frame_start;
        req.x           = point_x;
        req.y           = point_y;
        req.z           = point_z;
        if (filter_point(req, res)) kept_expect.push_back(res);
      end
      // a stalled request holds; otherwise load the next one or leave a gap
      if (!in_valid || !in_stall) begin
        if (pending_pts.size() != 0 && !chance(gap_pct(1'b0))) begin
          nxt = pending_pts.pop_front();
          in_valid    <= 1'b1;
          frame_start <= nxt.frame_start;
          point_x     <= nxt.x;
          point_y     <= nxt.y;
          point_z     <= nxt.z;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering.
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks accepted results in order, drives out_stall
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    kept_point_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (kept_expect.size() == 0) begin
          report_mismatch($sformatf("unexpected result x=%h y=%h z=%h ovf=%b",
                                    kept_x, kept_y, kept_z, table_overflow));
        end else begin
          want = kept_expect.pop_front();
          if (kept_x !== want.x)
            report_mismatch($sformatf("kept_x %h, want %h", kept_x, want.x));
          if (kept_y !== want.y)
            report_mismatch($sformatf("kept_y %h, want %h", kept_y, want.y));
          if (kept_z !== want.z)
            report_mismatch($sformatf("kept_z %h, want %h", kept_z, want.z));
          if (table_overflow !== want.overflow)
            report_mismatch($sformatf("table_overflow %b, want %b (x=%h)",
                                      table_overflow, want.overflow, want.x));
        end
      end
      out_stall <= (hold_left != 0) || chance(gap_pct(1'b1));
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Phase sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [24:0] inv_plan [RAND_PHASES];
    int unsigned fs_plan  [RAND_PHASES];
    point_req_t  p;
    // zero in inv_plan means draw a random size for that phase
    inv_plan = '{INV_UNIT, INV_MAX, 25'd1, INV_AT_RESET, 25'd0, 25'd0, 25'd4194304, 25'd0};
    fs_plan  = '{25, 25, 25, 3, 25, 25, 25, 25};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset size, 10 voxels per metre (edge 6553.6 in Q16.16).
    add_point(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    add_point(1'b0, 32'h0000_0100, 32'h0000_1800, 32'h0000_0100); // same voxel
    add_point(1'b0, 32'hFFFF_FF00, 32'hFFFF_E800, 32'h0000_0000); // toward zero
    add_point(1'b0, 32'hFFFE_0000, 32'h0001_0000, 32'h0000_0000);
    add_point(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    add_point(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    add_point(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF); // repeat
    add_point(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000); // new frame
    add_point(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    add_point(1'b0, 32'h0000_1999, 32'h0000_0000, 32'h0000_0000); // just below edge
    add_point(1'b0, 32'h0000_199A, 32'h0000_0000, 32'h0000_0000); // just above
    drain_phase();

    // Largest size: far points clamp to the index limits.
    write_inv(INV_MAX);
    add_point(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    add_point(1'b0, 32'h4000_0000, 32'h0800_0000, 32'hC000_0000); // clamps alike
    add_point(1'b0, 32'h07FF_FF00, 32'h07FF_FF00, 32'hF800_0000); // exactly at limit
    add_point(1'b0, 32'h0000_00FF, 32'h0000_0100, 32'hFFFF_FF00);
    add_point(1'b0, 32'h0000_0000, 32'h0000_01FF, 32'hFFFF_FE01);
    drain_phase();

    // Zero size: every point shares voxel 0.
    write_inv(25'd0);
    add_point(1'b1, 32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
    add_point(1'b0, $urandom(), $urandom(), $urandom());
    add_point(1'b1, $urandom(), $urandom(), $urandom());
    drain_phase();

    // Fill: at 1 voxel per metre, voxels (ix, 0, 0) for ix < 4096 start
    // their probe at 4096 different slots, so the fill stays cheap.
    write_inv(INV_UNIT);
    idle_mode = IDLE_BOTH;
    for (int ix = 0; ix < DEPTH; ix++)
      add_point(ix == 0, (ix << 16) | $urandom_range(0, 16'hFFFF),
                $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
    // full table: known voxels still drop, new ones overflow after a full search
    for (int k = 0; k < 8; k++) begin
      if (k % 2 == 0)
        add_point(1'b0, ($urandom_range(0, DEPTH - 1) << 16) | $urandom_range(0, 16'hFFFF),
                  32'd0 - $urandom_range(1, 16'hFFFF), $urandom_range(0, 16'hFFFF));
      else
        add_point(1'b0, (DEPTH + k) << 16, $urandom_range(0, 16'hFFFF), 32'h0000_0000);
    end
    drain_phase();

    // Random phases, cycling through the idling patterns.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      write_inv(inv_plan[ph] == 25'd0 ? 25'($urandom_range(1, 16777216)) : inv_plan[ph]);
      idle_mode = idle_mode_t'(ph % 4);
      if (ph == 0) hold_req <= 1'b1;
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        p = random_point(fs_plan[ph]);
        if (k == 0) p.frame_start = 1'b1;
        pending_pts.push_back(p);
      end
      drain_phase();
    end

    if (err_cnt == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
